// ===== sv/c3sf_pkg.sv =====
// Package for the 3x3 saturating convolution filter.
// Holds the word types, register codes, reset values and sizing constants.
// No dependencies.
`default_nettype none

package c3sf_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned COEF_BITS_DEF = 8;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned ROW_W      = 13;
  localparam int unsigned KROW_W     = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned MID_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH  = 4;
  localparam int          PIX_MAX    = 255;

  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST   = 12'd640;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST  = 12'd480;
  localparam logic [KROW_W-1:0] KERNEL_TOP_RST    = 24'hFFFFFF;
  localparam logic [KROW_W-1:0] KERNEL_MID_RST    = 24'hFF08FF;
  localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RST = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MID    = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             pad;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_word_t;

  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    window_t win;
    logic    border;
    logic    frame_end;
  } mid_entry_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             restart;
  } geom_t;

  typedef struct packed {
    logic [KROW_W-1:0] top;
    logic [KROW_W-1:0] mid;
    logic [KROW_W-1:0] bottom;
  } kernel_t;

endpackage

`default_nettype wire

// ===== sv/c3sf_fifo.sv =====
// Small first-in first-out queue of registers with an occupancy count.
// Standalone; the caller never pushes into a full queue.
`default_nettype none

module c3sf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [Width-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic      [Width-1:0]           data_o,
  output logic                            empty_o,
  output logic      [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/c3sf_front.sv =====
// Front part of the filter: raster position, line memory and 3x3 window.
// Classifies each accepted word and queues window snapshots; uses c3sf_pkg.
`default_nettype none

module c3sf_front #(
  parameter int unsigned MaxWidth = c3sf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire c3sf_pkg::geom_t                             geom_i,
  input  wire logic                                        push,
  input  wire c3sf_pkg::in_word_t                          in_word_i,
  output logic                                             full,
  input  wire logic [$clog2(c3sf_pkg::MID_DEPTH+1)-1:0]    mid_count_i,
  output logic                                             mid_push_o,
  output c3sf_pkg::mid_entry_t                             mid_entry_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned RowW = c3sf_pkg::ROW_W;
  localparam int unsigned PixW = c3sf_pkg::PIX_W;

  logic [2*PixW-1:0] line_mem [MaxWidth];

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   last_col;
  logic [31:0]       fw_ext;
  logic [RowW-1:0]   eff_h;
  logic              accept;
  logic [PixW-1:0]   pix;
  logic              produced, border, frame_end;

  logic              s1_v_q;
  logic [ColW-1:0]   c1_q;
  logic [PixW-1:0]   pix1_q;
  logic              prod1_q, bord1_q, fend1_q;
  logic [2*PixW-1:0] rd_q;
  logic              byp_q;
  logic [2*PixW-1:0] byp_data_q;
  logic [2*PixW-1:0] rd1;
  logic [2*PixW-1:0] wdata;

  c3sf_pkg::window_t win_q, win_d;

  assign full   = (32'(mid_count_i) + 32'(s1_v_q)) >= c3sf_pkg::MID_DEPTH;
  assign accept = push && !full;
  assign pix    = in_word_i.pad ? '0 : in_word_i.pixel_in;

  always_comb begin
    fw_ext = 32'(geom_i.frame_width);
    if (fw_ext < 32'd3) begin
      last_col = ColW'(2);
    end else if (fw_ext > 32'(MaxWidth)) begin
      last_col = ColW'(MaxWidth - 1);
    end else begin
      last_col = ColW'(fw_ext - 32'd1);
    end
    if (geom_i.frame_height < c3sf_pkg::DIM_W'(3)) begin
      eff_h = RowW'(3);
    end else begin
      eff_h = RowW'(geom_i.frame_height);
    end
  end

  always_comb begin
    produced  = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && (col_q != '0));
    border    = (col_q == ColW'(0)) || (col_q == ColW'(1)) ||
                (row_q == RowW'(1)) || (row_q == eff_h);
    frame_end = (row_q >= eff_h + 1'b1);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (geom_i.restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (row_q >= eff_h + 1'b1) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == last_col) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  assign rd1   = byp_q ? byp_data_q : rd_q;
  assign wdata = {rd1[PixW-1:0], pix1_q};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = rd1[2*PixW-1:PixW];
    win_d[1][2] = rd1[PixW-1:0];
    win_d[2][2] = pix1_q;
  end

  assign mid_push_o            = s1_v_q && prod1_q;
  assign mid_entry_o.win       = win_d;
  assign mid_entry_o.border    = bord1_q;
  assign mid_entry_o.frame_end = fend1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      win_q  <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= accept;
      if (s1_v_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c1_q       <= col_q;
      pix1_q     <= pix;
      prod1_q    <= produced;
      bord1_q    <= border;
      fend1_q    <= frame_end;
      rd_q       <= line_mem[col_q];
      byp_q      <= s1_v_q && (c1_q == col_q);
      byp_data_q <= wdata;
    end
    if (s1_v_q) begin
      line_mem[c1_q] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/c3sf_back.sv =====
// Back part of the filter: nine weighted taps, sum, clamp and border zeroing.
// Takes window snapshots from the middle queue; uses c3sf_pkg.
`default_nettype none

module c3sf_back #(
  parameter int unsigned CoefBits = c3sf_pkg::COEF_BITS_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire c3sf_pkg::kernel_t                        kernel_i,
  input  wire c3sf_pkg::mid_entry_t                     mid_entry_i,
  input  wire logic                                     mid_empty_i,
  output logic                                          mid_pop_o,
  input  wire logic [$clog2(c3sf_pkg::OUT_DEPTH+1)-1:0] out_count_i,
  output logic                                          out_push_o,
  output c3sf_pkg::out_word_t                           out_word_o
);

  localparam int unsigned CoefW = (CoefBits < 8) ? CoefBits : 8;
  localparam int unsigned ProdW = CoefW + 9;
  localparam int unsigned SumW  = ProdW + 4;
  localparam logic signed [SumW-1:0] SumMax = SumW'(c3sf_pkg::PIX_MAX);

  logic [c3sf_pkg::KROW_W-1:0] krow [3];
  logic signed [CoefW-1:0]     coef [3][3];
  logic signed [ProdW-1:0]     prod_d [3][3];
  logic signed [ProdW-1:0]     prod_q [3][3];
  logic signed [SumW-1:0]      sum;
  logic                        p1_v_q, p2_v_q;
  logic                        bord1_q, fend1_q;
  c3sf_pkg::out_word_t         word_d, word_q;

  assign mid_pop_o = !mid_empty_i &&
                     ((32'(out_count_i) + 32'(p1_v_q) + 32'(p2_v_q)) < c3sf_pkg::OUT_DEPTH);

  assign krow[0] = kernel_i.top;
  assign krow[1] = kernel_i.mid;
  assign krow[2] = kernel_i.bottom;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j]   = signed'(krow[i][8*j +: CoefW]);
        prod_d[i][j] = signed'({1'b0, mid_entry_i.win[i][j]}) * coef[i][j];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + prod_q[i][j];
      end
    end
    word_d.frame_end = fend1_q;
    if (bord1_q || (sum < 0)) begin
      word_d.pixel_out = '0;
    end else if (sum > SumMax) begin
      word_d.pixel_out = c3sf_pkg::PIX_W'(c3sf_pkg::PIX_MAX);
    end else begin
      word_d.pixel_out = sum[c3sf_pkg::PIX_W-1:0];
    end
  end

  assign out_push_o = p2_v_q;
  assign out_word_o = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      p1_v_q <= mid_pop_o;
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      prod_q  <= prod_d;
      bord1_q <= mid_entry_i.border;
      fend1_q <= mid_entry_i.frame_end;
    end
    if (p1_v_q) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/conv3x3_saturating_filter_top.sv =====
// Top level of the 3x3 saturating convolution filter.
// Uses c3sf_pkg, c3sf_front, c3sf_back and c3sf_fifo.
//
// The filter takes one pixel word per clock while full is low and gives at most one
// result word per clock; a word passes the line memory read, the middle queue, the
// multiply stage and the sum stage in that order before it reaches the result queue.
// Results lag the input by one row plus one pixel, so a frame of W x H pixels must be
// followed by W+1 pad words to flush the last row out. The line memory holds two rows
// in one array of MaxWidth entries and needs no clearing after reset. Configuration
// must be written only while no word is in flight; the block itself does not enforce
// this. Writing the width or height restarts the frame.
`default_nettype none

module conv3x3_saturating_filter_top #(
  parameter int unsigned MaxWidth = c3sf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned CoefBits = c3sf_pkg::COEF_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [c3sf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [c3sf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire c3sf_pkg::in_word_t                in_word_i,
  input  wire logic                              pop,
  output logic                                   empty,
  output c3sf_pkg::out_word_t                    out_word_o
);

  localparam int unsigned MidW = $bits(c3sf_pkg::mid_entry_t);
  localparam int unsigned OutW = $bits(c3sf_pkg::out_word_t);

  logic [c3sf_pkg::DIM_W-1:0] frame_width_q, frame_height_q;
  c3sf_pkg::kernel_t          kernel_q;
  c3sf_pkg::geom_t            geom;

  logic                                         mid_push, mid_pop, mid_empty;
  c3sf_pkg::mid_entry_t                         mid_in, mid_out;
  logic [$clog2(c3sf_pkg::MID_DEPTH+1)-1:0]     mid_count;
  logic                                         out_push;
  c3sf_pkg::out_word_t                          out_in;
  logic [$clog2(c3sf_pkg::OUT_DEPTH+1)-1:0]     out_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= c3sf_pkg::FRAME_WIDTH_RST;
      frame_height_q  <= c3sf_pkg::FRAME_HEIGHT_RST;
      kernel_q.top    <= c3sf_pkg::KERNEL_TOP_RST;
      kernel_q.mid    <= c3sf_pkg::KERNEL_MID_RST;
      kernel_q.bottom <= c3sf_pkg::KERNEL_BOTTOM_RST;
    end else if (cfg_we_i) begin
      case (c3sf_pkg::cfg_reg_e'(cfg_idx_i))
        c3sf_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[c3sf_pkg::DIM_W-1:0];
        c3sf_pkg::REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i[c3sf_pkg::DIM_W-1:0];
        c3sf_pkg::REG_KERNEL_TOP:    kernel_q.top    <= cfg_data_i;
        c3sf_pkg::REG_KERNEL_MID:    kernel_q.mid    <= cfg_data_i;
        c3sf_pkg::REG_KERNEL_BOTTOM: kernel_q.bottom <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign geom.frame_width  = frame_width_q;
  assign geom.frame_height = frame_height_q;
  assign geom.restart      = cfg_we_i &&
                             ((cfg_idx_i == c3sf_pkg::REG_FRAME_WIDTH) ||
                              (cfg_idx_i == c3sf_pkg::REG_FRAME_HEIGHT));

  c3sf_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .push        (push),
    .in_word_i   (in_word_i),
    .full        (full),
    .mid_count_i (mid_count),
    .mid_push_o  (mid_push),
    .mid_entry_o (mid_in)
  );

  c3sf_fifo #(
    .Width (MidW),
    .Depth (c3sf_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  c3sf_back #(
    .CoefBits (CoefBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kernel_i    (kernel_q),
    .mid_entry_i (mid_out),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .out_push_o  (out_push),
    .out_word_o  (out_in)
  );

  c3sf_fifo #(
    .Width (OutW),
    .Depth (c3sf_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .pop_i   (pop),
    .data_o  (out_word_o),
    .empty_o (empty),
    .count_o (out_count)
  );

endmodule

`default_nettype wire

// ===== sv/c3sf_checker.sv =====
// Port-level checker for the 3x3 saturating convolution filter, with its bind.
// Uses c3sf_pkg; attaches to conv3x3_saturating_filter_top.
`default_nettype none

module c3sf_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 push,
  input wire logic                 full,
  input wire logic                 pop,
  input wire logic                 empty,
  input wire c3sf_pkg::out_word_t  out_word_o
);

  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push && !full) begin
      seen_q <= 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queue not idle in reset");

  a_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_word_o))
    else $error("waiting result word changed or vanished");

  a_frame_end_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_word_o.frame_end |-> out_word_o.pixel_out == '0)
    else $error("last word of a frame is not a border zero");

  a_no_output_without_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> seen_q)
    else $error("result word without any accepted input word");

endmodule

bind conv3x3_saturating_filter_top c3sf_checker u_c3sf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .out_word_o (out_word_o)
);

`default_nettype wire

// ===== sim/tb_conv3x3_saturating_filter_top.sv =====
// Self-checking testbench for conv3x3_saturating_filter_top: streams small and extreme
// frames with pad and flush noise, predicts every filtered word and compares each field.
// Depends on c3sf_pkg and the filter RTL.
`default_nettype none

module tb_conv3x3_saturating_filter_top;
  import c3sf_pkg::*;

  typedef enum bit {PIX_RANDOM, PIX_EXTREME} pix_mode_e;

  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 200;
  localparam int SHORT_RUN      = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(REG_KERNEL_BOTTOM + 1);

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push       = 1'b0;
  logic                  full;
  in_word_t              in_word_i  = '0;
  logic                  pop        = 1'b0;
  logic                  empty;
  out_word_t             out_word_o;

  conv3x3_saturating_filter_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .pop        (pop),
    .empty      (empty),
    .out_word_o (out_word_o)
  );

  // Predictor state.
  logic [DIM_W-1:0]  geom_width;
  logic [DIM_W-1:0]  geom_height;
  logic [KROW_W-1:0] krow_top;
  logic [KROW_W-1:0] krow_mid;
  logic [KROW_W-1:0] krow_bot;
  logic [PIX_W-1:0]  line_prev  [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]  line_prev2 [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]  taps [3][3];
  logic [10:0]       pos_col;
  logic [ROW_W-1:0]  pos_row;

  in_word_t  pixel_backlog[$];
  out_word_t expected_pixels[$];
  out_word_t oldest_pixel;

  bit idle_enable = 1'b1;
  int send_gap, take_gap, quiet_cycles;
  int words_queued, words_sent, results_checked, mismatch_count, phase_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int active_width(logic [DIM_W-1:0] w);
    if (w < 3) return 3;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return int'(w);
  endfunction

  function automatic int active_height(logic [DIM_W-1:0] h);
    if (h < 3) return 3;
    return int'(h);
  endfunction

  task automatic reset_predictor();
    int i, j;
    geom_width  = FRAME_WIDTH_RST;
    geom_height = FRAME_HEIGHT_RST;
    krow_top    = KERNEL_TOP_RST;
    krow_mid    = KERNEL_MID_RST;
    krow_bot    = KERNEL_BOTTOM_RST;
    for (i = 0; i < MAX_WIDTH_DEF; i++) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        taps[i][j] = '0;
    pos_col = '0;
    pos_row = '0;
  endtask

  task automatic convolve_step(input in_word_t w);
    int wid, hgt, c, r, orow, ocol, sum, i, j;
    logic [PIX_W-1:0]  pix;
    logic [KROW_W-1:0] krow [3];
    logic signed [7:0] k;
    out_word_t         res;
    wid = active_width(geom_width);
    hgt = active_height(geom_height);
    c = int'(pos_col);
    r = int'(pos_row);
    pix = w.pad ? '0 : w.pixel_in;
    if (c >= wid) c = wid - 1;
    for (i = 0; i < 3; i++) begin
      taps[i][0] = taps[i][1];
      taps[i][1] = taps[i][2];
    end
    taps[0][2] = line_prev2[c];
    taps[1][2] = line_prev[c];
    taps[2][2] = pix;
    line_prev2[c] = line_prev[c];
    line_prev[c]  = pix;
    if (r >= 2 || (r == 1 && c >= 1)) begin
      if (c == 0) begin
        orow = r - 2;
        ocol = wid - 1;
      end else begin
        orow = r - 1;
        ocol = c - 1;
      end
      res.pixel_out = '0;
      if (orow != 0 && orow != hgt - 1 && ocol != 0 && ocol != wid - 1) begin
        krow[0] = krow_top;
        krow[1] = krow_mid;
        krow[2] = krow_bot;
        sum = 0;
        for (i = 0; i < 3; i++)
          for (j = 0; j < 3; j++) begin
            k = krow[i][8*j +: 8];
            sum += int'(taps[i][j]) * int'(k);
          end
        if (sum < 0) sum = 0;
        if (sum > PIX_MAX) sum = PIX_MAX;
        res.pixel_out = sum[PIX_W-1:0];
      end
      res.frame_end = (r == hgt + 1);
      expected_pixels.push_back(res);
    end
    if (r >= hgt + 1) begin
      pos_col = '0;
      pos_row = '0;
    end else begin
      c++;
      if (c >= wid) begin
        c = 0;
        r++;
      end
      pos_col = 11'(c);
      pos_row = ROW_W'(r);
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("ERROR: %s", what);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: begin
        geom_width = data[DIM_W-1:0];
        pos_col = '0;
        pos_row = '0;
      end
      REG_FRAME_HEIGHT: begin
        geom_height = data[DIM_W-1:0];
        pos_col = '0;
        pos_row = '0;
      end
      REG_KERNEL_TOP:    krow_top = data[KROW_W-1:0];
      REG_KERNEL_MID:    krow_mid = data[KROW_W-1:0];
      REG_KERNEL_BOTTOM: krow_bot = data[KROW_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [KROW_W-1:0] rand_kernel_row();
    logic [KROW_W-1:0] v;
    int k;
    v = KROW_W'($urandom);
    if ($urandom_range(0, 3) != 0)
      for (k = 0; k < 3; k++) v[8*k +: 8] = 8'($urandom_range(0, 8)) - 8'd4;
    return v;
  endfunction

  task automatic queue_word(input logic [PIX_W-1:0] pix, input logic is_pad);
    in_word_t w;
    w.pixel_in = pix;
    w.pad      = is_pad;
    pixel_backlog.push_back(w);
    words_queued++;
  endtask

  task automatic queue_frame(pix_mode_e mode, int noise_pct, int first, int last);
    int wid, hgt, total, n;
    logic [PIX_W-1:0] pix;
    logic is_pad;
    wid = active_width(geom_width);
    hgt = active_height(geom_height);
    total = wid * hgt + wid + 1;
    if (last < 0 || last > total) last = total;
    for (n = first; n < last; n++) begin
      if (mode == PIX_EXTREME) pix = $urandom_range(0, 1) ? '1 : '0;
      else pix = PIX_W'($urandom);
      is_pad = (n >= wid * hgt);
      if ($urandom_range(0, 99) < noise_pct) is_pad = !is_pad;
      queue_word(pix, is_pad);
    end
  endtask

  task automatic wait_drained();
    while (words_sent != words_queued || expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    phase_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        convolve_step(in_word_i);
        words_sent++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pixel_backlog.size() != 0) begin
          in_word_i <= pixel_backlog.pop_front();
          push      <= 1'b1;
          if (idle_enable && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result word %h arrived with none expected", out_word_o));
        end else begin
          oldest_pixel = expected_pixels.pop_front();
          if (out_word_o.pixel_out !== oldest_pixel.pixel_out)
            report_mismatch($sformatf("result %0d pixel_out %0d, expected %0d", results_checked,
                                      out_word_o.pixel_out, oldest_pixel.pixel_out));
          if (out_word_o.frame_end !== oldest_pixel.frame_end)
            report_mismatch($sformatf("result %0d frame_end %b, expected %b", results_checked,
                                      out_word_o.frame_end, oldest_pixel.frame_end));
          results_checked++;
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (idle_enable && $urandom_range(0, 15) == 0) take_gap = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int n, f, frames, noise, start;
    logic [CFG_IDX_W-1:0] idx;
    bit need_restart, paused_once;
    reset_predictor();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Upper data bits must be masked off; spare indexes must change nothing.
    write_reg(REG_FRAME_WIDTH, 24'hA5A003);
    write_reg(REG_FRAME_HEIGHT, 24'h5A5003);
    idx = CFG_IDX_SPARE;
    do begin
      write_reg(idx, '1);
      idx++;
    end while (idx != '0);
    for (n = 0; n < 13; n++) queue_word((n == 4) ? 8'hFF : 8'h00, n >= 9);
    for (n = 0; n < 13; n++) queue_word((n == 4) ? 8'h00 : 8'hFF, (n >= 9) ^ (n == 1 || n == 10));
    settle();

    write_reg(REG_FRAME_WIDTH, 24'hFFF000);
    write_reg(REG_FRAME_HEIGHT, 24'h000001);
    write_reg(REG_KERNEL_TOP, 24'h7F807F);
    write_reg(REG_KERNEL_MID, 24'h807F80);
    write_reg(REG_KERNEL_BOTTOM, 24'h7F807F);
    queue_frame(PIX_EXTREME, 0, 0, -1);
    queue_frame(PIX_RANDOM, 0, 0, -1);
    settle();

    write_reg(REG_FRAME_WIDTH, 24'h000002);
    write_reg(REG_FRAME_HEIGHT, 24'h000002);
    write_reg(REG_KERNEL_TOP, 24'h000000);
    write_reg(REG_KERNEL_MID, 24'h000100);
    write_reg(REG_KERNEL_BOTTOM, 24'h000000);
    queue_frame(PIX_RANDOM, 0, 0, -1);
    queue_frame(PIX_RANDOM, 10, 0, -1);

    start = words_queued;
    need_restart = 1'b1;
    paused_once = 1'b0;
    while (words_queued - start < RANDOM_WORDS) begin
      settle();
      if (need_restart || $urandom_range(0, 1))
        write_reg(REG_FRAME_WIDTH, {DIM_W'($urandom), DIM_W'($urandom_range(3, 10))});
      if (need_restart || $urandom_range(0, 1))
        write_reg(REG_FRAME_HEIGHT, {DIM_W'($urandom), DIM_W'($urandom_range(3, 7))});
      if ($urandom_range(0, 1)) write_reg(REG_KERNEL_TOP, rand_kernel_row());
      if ($urandom_range(0, 1)) write_reg(REG_KERNEL_MID, rand_kernel_row());
      if ($urandom_range(0, 1)) write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
      need_restart = 1'b0;
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        noise = $urandom_range(0, 1) ? 0 : 6;
        if (!paused_once) begin
          queue_frame(PIX_RANDOM, noise, 0, 12);
          wait_drained();
          queue_frame(PIX_RANDOM, noise, 12, -1);
          paused_once = 1'b1;
        end else if (f == frames - 1 && $urandom_range(0, 5) == 0) begin
          queue_frame(PIX_RANDOM, noise, 0, $urandom_range(1, 20));
          need_restart = 1'b1;
        end else begin
          queue_frame(($urandom_range(0, 7) == 0) ? PIX_EXTREME : PIX_RANDOM, noise, 0, -1);
        end
      end
    end

    settle();
    write_reg(REG_FRAME_WIDTH, 24'hFFFFFF);
    write_reg(REG_FRAME_HEIGHT, 24'h000003);
    write_reg(REG_KERNEL_MID, rand_kernel_row());
    queue_frame(PIX_RANDOM, 1, 0, SHORT_RUN);
    settle();
    write_reg(REG_FRAME_WIDTH, 24'h000003);
    write_reg(REG_FRAME_HEIGHT, 24'h000FFF);
    write_reg(REG_KERNEL_TOP, rand_kernel_row());
    queue_frame(PIX_RANDOM, 1, 0, SHORT_RUN);

    settle();
    idle_enable = 1'b0;
    write_reg(REG_FRAME_WIDTH, 24'h000006);
    write_reg(REG_FRAME_HEIGHT, 24'h000004);
    write_reg(REG_KERNEL_BOTTOM, rand_kernel_row());
    queue_frame(PIX_RANDOM, 0, 0, -1);
    queue_frame(PIX_RANDOM, 5, 0, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Summary: %0d pixel words sent under %0d register settings, %0d result words checked.",
             words_sent, phase_count, results_checked);
    $display("Full frames ran from 3x3 to 10x7, with short runs at the widest and tallest sizes.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/c3sf_pkg.sv
sv/c3sf_fifo.sv
sv/c3sf_front.sv
sv/c3sf_back.sv
sv/conv3x3_saturating_filter_top.sv
sv/c3sf_checker.sv
sim/tb_conv3x3_saturating_filter_top.sv
